@@ sv/packed_depth_pixel_colorizer_core_defines.svh @@
// Assertion macros shared by the colorizer checker.
`ifndef PACKED_DEPTH_PIXEL_COLORIZER_CORE_DEFINES_SVH
`define PACKED_DEPTH_PIXEL_COLORIZER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/pdpc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the depth colorizer.
package pdpc_pkg;

  // Full-scale depth and channel maximum
  localparam int unsigned DEPTH_FULL = 4084;
  localparam int unsigned CHAN_MAX   = 255;

  // Configuration register indexes
  localparam logic CFG_DEPTH_MODE  = 1'b0;
  localparam logic CFG_HUE_PALETTE = 1'b1;

  // Ramp numerator width: holds 0..DEPTH_FULL after clamping
  localparam int unsigned NUM_W = 12;

  // floor(n*255/4084) == (n * SCALE_MULT) >> SCALE_SHIFT for all n in 0..4084
  localparam logic [28:0] SCALE_MULT  = 29'd268172790;
  localparam int unsigned SCALE_SHIFT = 32;

  // Signed constants for the hue triangle
  localparam logic signed [16:0] D1_S = 17'sd4084;
  localparam logic signed [16:0] D2_S = 17'sd8168;
  localparam logic signed [16:0] D3_S = 17'sd12252;
  localparam logic signed [16:0] D4_S = 17'sd16336;

  typedef logic [NUM_W-1:0] num_t;

  // Per-pixel numerators handed from the ramp stage to the scaling stage
  typedef struct packed {
    logic bypass;
    num_t num0;
    num_t num1;
    num_t num2;
  } ramp_t;

  function automatic logic signed [16:0] abs17(input logic signed [16:0] v);
    abs17 = (v < 0) ? -v : v;
  endfunction

  // Clamp a signed numerator into 0..DEPTH_FULL
  function automatic num_t clamp_num(input logic signed [16:0] v);
    if (v <= 0) begin
      clamp_num = '0;
    end else if (v >= D1_S) begin
      clamp_num = NUM_W'(DEPTH_FULL);
    end else begin
      clamp_num = v[NUM_W-1:0];
    end
  endfunction

  // floor(n*255/4084) by reciprocal multiply
  function automatic logic [7:0] scale255(input num_t n);
    logic [40:0] prod;
    prod = 41'(n) * 41'(SCALE_MULT);
    scale255 = prod[SCALE_SHIFT+7:SCALE_SHIFT];
  endfunction

endpackage

@@ sv/pdpc_ramp.sv @@
// Depth unpack and ramp numerator logic for one pixel.
module pdpc_ramp import pdpc_pkg::*; (
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  input  logic       depth_mode,
  input  logic       hue_palette,
  output ramp_t      ramp
);

  logic [NUM_W-1:0]   depth;
  logic [14:0]        tri_pos;
  logic signed [16:0] tri_s;

  // Unpack depth: fine, middle, then coarse byte, offset by 4
  always_comb begin
    if (red != 8'hFF) begin
      depth = NUM_W'(red) + NUM_W'(4);
    end else if (green != 8'hFF) begin
      depth = {2'b00, green, 2'b00} + NUM_W'(4);
    end else begin
      depth = {blue, 4'b0000} + NUM_W'(4);
    end
  end

  // Position on the hue triangle: 6*(D - depth)
  assign tri_pos = 15'(15'(DEPTH_FULL - 32'(depth)) * 15'd6);
  assign tri_s   = signed'({2'b00, tri_pos});

  // Select pass-through, grayscale or hue numerators
  always_comb begin
    ramp.bypass = !depth_mode;
    if (!depth_mode) begin
      ramp.num0 = NUM_W'(blue);
      ramp.num1 = NUM_W'(green);
      ramp.num2 = NUM_W'(red);
    end else if (!hue_palette) begin
      ramp.num0 = depth;
      ramp.num1 = depth;
      ramp.num2 = depth;
    end else begin
      ramp.num0 = clamp_num(D2_S - abs17(tri_s - D4_S));
      ramp.num1 = clamp_num(D2_S - abs17(tri_s - D2_S));
      ramp.num2 = clamp_num(abs17(tri_s - D3_S) - D1_S);
    end
  end

endmodule

@@ sv/packed_depth_pixel_colorizer_core.sv @@
// Top level of the packed depth pixel colorizer: three-stage stream pipeline.
// Each request goes through the input, numerator and output registers to the master side.
// Throughput: one pixel per cycle while m_axis_tready holds; set by the three registered
// stages, each with its own valid bit, so a request is taken whenever any stage can advance.
// Reset (rst, synchronous, active high) empties the pipeline and clears both
// configuration registers to 0 (pass-through, grayscale).
module packed_depth_pixel_colorizer_core import pdpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  // Pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] blue_in, [15:8] green_in, [23:16] red_in
  // Pixel output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] byte0_out, [15:8] byte1_out, [23:16] byte2_out
);

  logic        depth_mode;
  logic        hue_palette;

  logic        v0, v1, v2;
  logic        adv0, adv1, adv2;
  logic [7:0]  blue0, green0, red0;
  ramp_t       ramp_c;
  ramp_t       ramp1;
  logic [23:0] out2;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode  <= 1'b0;
      hue_palette <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEPTH_MODE:  depth_mode  <= cfg_data;
        CFG_HUE_PALETTE: hue_palette <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage advances when empty or when the next one frees up
  assign adv2 = !v2 || m_axis_tready;
  assign adv1 = !v1 || adv2;
  assign adv0 = !v0 || adv1;
  assign s_axis_tready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv0) v0 <= s_axis_tvalid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv0 && s_axis_tvalid) begin
      blue0  <= s_axis_tdata[7:0];
      green0 <= s_axis_tdata[15:8];
      red0   <= s_axis_tdata[23:16];
    end
  end

  pdpc_ramp u_ramp (
    .blue        (blue0),
    .green       (green0),
    .red         (red0),
    .depth_mode  (depth_mode),
    .hue_palette (hue_palette),
    .ramp        (ramp_c)
  );

  // Numerator register
  always_ff @(posedge clk) begin
    if (adv1 && v0) begin
      ramp1 <= ramp_c;
    end
  end

  // Scale to 0..255 or pass the bytes through, then hold for the master side
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      if (ramp1.bypass) begin
        out2 <= {ramp1.num2[7:0], ramp1.num1[7:0], ramp1.num0[7:0]};
      end else begin
        out2 <= {scale255(ramp1.num2), scale255(ramp1.num1), scale255(ramp1.num0)};
      end
    end
  end

  assign m_axis_tvalid = v2;
  assign m_axis_tdata  = out2;

endmodule

@@ sv/pdpc_checker.sv @@
// Port-level checker for the colorizer, bound to the top level.
`include "packed_depth_pixel_colorizer_core_defines.svh"

module pdpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // A stalled result holds its value
  `PDPC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // Reset empties the pipeline
  `PDPC_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_axis_tvalid, "output valid right after reset")

  // With no result waiting, every stage can advance, so a request is taken
  `PDPC_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")

endmodule

bind packed_depth_pixel_colorizer_core pdpc_checker u_pdpc_checker (.*);

@@ bench/tb_packed_depth_pixel_colorizer_core.sv @@
// Self-checking stream testbench for the packed depth pixel colorizer core.
module tb_packed_depth_pixel_colorizer_core;
  import pdpc_pkg::*;

  localparam int FULL_SCALE = DEPTH_FULL;
  localparam int LEVEL_MAX  = CHAN_MAX;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 7;
  localparam int RANDOM_PER_PHASE = 120;

  // Register settings per phase, phase 0 in bit 0
  localparam logic [PHASES-1:0] PHASE_DEPTH = 7'b0110110;
  localparam logic [PHASES-1:0] PHASE_HUE   = 7'b0011100;

  // Byte [0] sits in the low bits, as on the tdata buses
  typedef logic [2:0][7:0] color_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // Local copy of the configuration registers
  logic depth_on = 1'b0;
  logic hue_on   = 1'b0;

  color_t pending_pixels[$];
  color_t expected_colors[$];
  int     errors = 0;
  int     gap_left = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int     ready_step = 0;
  color_t want;

  packed_depth_pixel_colorizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamped triangle level for one hue channel
  function automatic logic [7:0] hue_level(input int num);
    if (num <= 0) begin
      return 8'd0;
    end else if (num >= FULL_SCALE) begin
      return 8'(LEVEL_MAX);
    end
    return 8'((num * LEVEL_MAX) / FULL_SCALE);
  endfunction

  // Expected output color for one input pixel under the current registers
  function automatic color_t colorize(input color_t px);
    int     blue;
    int     green;
    int     red;
    int     depth;
    int     tri_pos;
    int     tri_off;
    color_t res;
    blue  = px[0];
    green = px[1];
    red   = px[2];
    if (!depth_on) begin
      return px;
    end
    // Unpack depth: fine part in red, then green, then coarse blue
    if (red < 255) begin
      depth = red;
    end else if (green < 255) begin
      depth = 4 * green;
    end else begin
      depth = 16 * blue;
    end
    depth = depth + 4;
    if (!hue_on) begin
      res[0] = 8'((depth * LEVEL_MAX) / FULL_SCALE);
      res[1] = res[0];
      res[2] = res[0];
      return res;
    end
    tri_pos = 6 * (FULL_SCALE - depth);
    tri_off = tri_pos - 4 * FULL_SCALE;
    res[0] = hue_level(2 * FULL_SCALE - ((tri_off < 0) ? -tri_off : tri_off));
    tri_off = tri_pos - 2 * FULL_SCALE;
    res[1] = hue_level(2 * FULL_SCALE - ((tri_off < 0) ? -tri_off : tri_off));
    tri_off = tri_pos - 3 * FULL_SCALE;
    res[2] = hue_level(((tri_off < 0) ? -tri_off : tri_off) - FULL_SCALE);
    return res;
  endfunction

  // Random pixel spread over the red, green and blue depth paths
  function automatic color_t random_pixel();
    color_t px;
    px[0] = 8'($urandom);
    px[1] = 8'($urandom);
    px[2] = 8'($urandom);
    case ($urandom_range(0, 3))
      0: px[2] = 8'($urandom_range(0, 254));
      1: begin
        px[2] = 8'hFF;
        px[1] = 8'($urandom_range(0, 254));
      end
      2: begin
        px[2] = 8'hFF;
        px[1] = 8'hFF;
      end
      default: ;
    endcase
    return px;
  endfunction

  // Write one configuration register and track it locally
  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DEPTH_MODE) begin
      depth_on = val;
    end else begin
      hue_on = val;
    end
  endtask

  // Wait until every queued pixel has been sent and every result checked
  task automatic drain();
    do @(posedge clk);
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_colors.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Queue the directed pixels: every depth path at its ends
  task automatic push_directed();
    color_t px;
    px = {8'd0,   8'd0,   8'd0};   pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd254, 8'd255, 8'd255}; pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'd0,   8'd0};   pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'd254, 8'd255}; pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'd255, 8'd0};   pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'd255, 8'd255}; pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'd255, 8'd128}; pending_pixels.insert(pending_pixels.size(), px);
    px = {8'd255, 8'hAA,  8'h55};  pending_pixels.insert(pending_pixels.size(), px);
  endtask

  // Stimulus: configuration phases, directed pixels, then random pixels
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_DEPTH_MODE, PHASE_DEPTH[p]);
      write_reg(CFG_HUE_PALETTE, PHASE_HUE[p]);
      if (p < 3) begin
        push_directed();
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        pending_pixels.insert(pending_pixels.size(), random_pixel());
      end
      drain();
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Sender: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_colors.insert(expected_colors.size(), colorize(s_axis_tdata));
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pixels.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result and advance the stall pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (want[k] !== m_axis_tdata[k*8 +: 8]) begin
            $display("%0t: byte%0d_out mismatch, expected %0d, actual %0d",
                     $time, k, want[k], m_axis_tdata[k*8 +: 8]);
            errors++;
          end
        end
      end
    end
    if (ready_step == 15) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'($urandom & $urandom);
      endcase
      ready_step = 0;
    end else begin
      ready_step++;
    end
    m_axis_tready <= ready_pattern[ready_step];
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/pdpc_pkg.sv
sv/pdpc_ramp.sv
sv/packed_depth_pixel_colorizer_core.sv
sv/pdpc_checker.sv
bench/tb_packed_depth_pixel_colorizer_core.sv
